// ----- hw/rtl/nmea_sentence_framer_unit_macros.svh -----
// Assertion macros used by the framer back end.
`ifndef NMEA_SENTENCE_FRAMER_UNIT_MACROS_SVH
`define NMEA_SENTENCE_FRAMER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NSF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("framer check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define NSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("framer check failed in the next cycle");

`endif

// ----- hw/rtl/nsf_pkg.sv -----
`timescale 1ns / 1ps

package nsf_pkg;

   // Framing characters.
   localparam logic [7:0] StartChar = 8'h24;
   localparam logic [7:0] EndChar   = 8'h2A;
   localparam logic [7:0] Wildcard  = 8'h2A;

   // Header length and known sentence patterns.
   localparam int HeaderLen      = 5;
   localparam int KnownKinds     = 4;
   localparam int SentenceKinds  = 4;

   // Sentence type codes.
   localparam logic [2:0] TypeNone = 3'd0;
   localparam logic [2:0] TypeGsa  = 3'd1;
   localparam logic [2:0] TypeGga  = 3'd2;
   localparam logic [2:0] TypeRmc  = 3'd3;
   localparam logic [2:0] TypeZda  = 3'd4;

   typedef logic [0:HeaderLen-1][7:0] nsf_header_type;

   localparam nsf_header_type NsfPatterns [KnownKinds] = '{
      '{"G", "*", "G", "S", "A"},
      '{"G", "*", "G", "G", "A"},
      '{"G", "*", "R", "M", "C"},
      '{"G", "*", "Z", "D", "A"}
   };

   localparam logic [2:0] NsfTypeCodes [KnownKinds] = '{TypeGsa, TypeGga, TypeRmc, TypeZda};

   // Framer phases.
   typedef enum logic [1:0] {
      PH_HUNT,
      PH_PAYLOAD,
      PH_DIGIT_HI,
      PH_DIGIT_LO
   } nsf_phase_type;

   // One classified character as it travels from front to back.
   typedef struct packed {
      logic [7:0] data;
      logic       is_start;
      logic       is_end;
      logic [3:0] hex;
   } nsf_item_type;

   // Hex digit value; anything that is not a hex digit counts as zero.
   function automatic logic [3:0] nsf_hex_value(logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= "0" && c <= "9") v = 4'(c - "0");
      else if (c >= "A" && c <= "F") v = 4'(c - "A" + 8'd10);
      else if (c >= "a" && c <= "f") v = 4'(c - "a" + 8'd10);
      return v;
   endfunction

   // Match the header against the patterns; the lowest matching pattern wins.
   function automatic logic [2:0] nsf_find_type(nsf_header_type hdr);
      logic [2:0] kind;
      logic       hit;
      kind = TypeNone;
      for (int k = KnownKinds - 1; k >= 0; k--) begin
         hit = 1'b1;
         for (int i = 0; i < HeaderLen; i++) begin
            if (NsfPatterns[k][i] != Wildcard && NsfPatterns[k][i] != hdr[i]) hit = 1'b0;
         end
         if (hit && k < SentenceKinds) kind = NsfTypeCodes[k];
      end
      return kind;
   endfunction

endpackage

// ----- hw/rtl/nsf_front.sv -----
`timescale 1ns / 1ps

module nsf_front import nsf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_rx_byte,
   output logic         out_valid,
   input  logic         out_stall,
   output nsf_item_type out_item
);

   logic         valid_ff;
   logic         valid_in;
   nsf_item_type item_ff;
   nsf_item_type item_in;

   // Classify the incoming character.
   always_comb begin
      item_in.data     = req_rx_byte;
      item_in.is_start = (req_rx_byte == StartChar);
      item_in.is_end   = (req_rx_byte == EndChar);
      item_in.hex      = nsf_hex_value(req_rx_byte);
   end

   // The stage holds while its transaction waits on the queue.
   assign req_stall = valid_ff && out_stall;
   assign valid_in  = req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ----- hw/rtl/nsf_queue.sv -----
`timescale 1ns / 1ps

module nsf_queue import nsf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_stall,
   input  nsf_item_type in_item,
   output logic         out_valid,
   input  logic         out_stall,
   output nsf_item_type out_item
);

   nsf_item_type entry_ff [2];
   logic         wr_ptr_ff;
   logic         wr_ptr_in;
   logic         rd_ptr_ff;
   logic         rd_ptr_in;
   logic [1:0]   count_ff;
   logic [1:0]   count_in;
   logic         push;
   logic         pop;

   // Two entries let the front and back stall independently.
   assign in_stall  = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;
   assign out_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// ----- hw/rtl/nsf_back.sv -----
`timescale 1ns / 1ps
`include "nmea_sentence_framer_unit_macros.svh"

module nsf_back import nsf_pkg::*; #(
   parameter int MAX_PAYLOAD = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_stall,
   input  nsf_item_type in_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic         rsp_checksum_ok,
   output logic [2:0]   rsp_sentence_type,
   output logic [7:0]   rsp_talker_char,
   output logic [7:0]   rsp_payload_length,
   output logic         rsp_length_overflow
);

   localparam int CountWidth = $clog2(MAX_PAYLOAD + 1);
   localparam logic [CountWidth-1:0] CountMax = CountWidth'(MAX_PAYLOAD);

   nsf_phase_type         phase_ff;
   nsf_phase_type         phase_in;
   logic [7:0]            xor_ff;
   logic [CountWidth-1:0] count_ff;
   logic [3:0]            high_ff;
   logic                  ovf_ff;
   nsf_header_type        hdr_ff;
   logic                  rsp_valid_ff;
   logic                  ok_ff;
   logic [2:0]            type_ff;
   logic [7:0]            talker_ff;
   logic [7:0]            length_ff;
   logic                  ovf_out_ff;

   logic take;
   logic can_take;
   logic start_frame;
   logic add_byte;
   logic load_high;
   logic emit;

   // A closing digit needs room in the output register; other characters do not.
   assign can_take = (phase_ff != PH_DIGIT_LO) || !rsp_valid_ff || !rsp_stall;
   assign take     = in_valid && can_take;
   assign in_stall = !can_take;

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         unique case (phase_ff)
            PH_HUNT:     if (in_item.is_start) phase_in = PH_PAYLOAD;
            PH_PAYLOAD:  if (in_item.is_end) phase_in = PH_DIGIT_HI;
            PH_DIGIT_HI: phase_in = PH_DIGIT_LO;
            PH_DIGIT_LO: phase_in = PH_HUNT;
            default:     phase_in = PH_HUNT;
         endcase
      end
   end

   // Datapath enables for the current phase.
   always_comb begin
      start_frame = 1'b0;
      add_byte    = 1'b0;
      load_high   = 1'b0;
      emit        = 1'b0;
      if (take) begin
         unique case (phase_ff)
            PH_HUNT:     start_frame = in_item.is_start;
            PH_PAYLOAD:  add_byte = !in_item.is_end;
            PH_DIGIT_HI: load_high = 1'b1;
            PH_DIGIT_LO: emit = 1'b1;
            default:     emit = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // Running XOR, saturating length and overflow flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (start_frame) begin
         count_ff <= '0;
      end else if (add_byte && count_ff < CountMax) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start_frame) begin
         xor_ff  <= 8'd0;
         ovf_ff  <= 1'b0;
         high_ff <= 4'd0;
      end else begin
         if (add_byte) begin
            xor_ff <= xor_ff ^ in_item.data;
            if (count_ff >= CountMax) ovf_ff <= 1'b1;
         end
         if (load_high) high_ff <= in_item.hex;
      end
   end

   // Header capture: each byte lands at its own position.
   always_ff @(posedge clock) begin
      for (int i = 0; i < HeaderLen; i++) begin
         if (add_byte && count_ff == CountWidth'(i)) begin
            hdr_ff[i] <= in_item.data;
         end
      end
   end

   // Output register with the finished frame summary.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         ok_ff      <= ({high_ff, in_item.hex} == xor_ff);
         type_ff    <= (count_ff >= CountWidth'(HeaderLen)) ? nsf_find_type(hdr_ff) : TypeNone;
         talker_ff  <= (count_ff >= CountWidth'(2)) ? hdr_ff[1] : 8'd0;
         length_ff  <= 8'(count_ff);
         ovf_out_ff <= ovf_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_checksum_ok     = ok_ff;
   assign rsp_sentence_type   = type_ff;
   assign rsp_talker_char     = talker_ff;
   assign rsp_payload_length  = length_ff;
   assign rsp_length_overflow = ovf_out_ff;

   // Consistency checks.
   `NSF_ASSERT_NEXT(a_emit_gives_rsp, clock, reset, emit, rsp_valid_ff)
   `NSF_ASSERT_NEXT(a_start_opens, clock, reset, start_frame, phase_ff == PH_PAYLOAD && count_ff == '0)
   `NSF_ASSERT_SAME(a_count_bound, clock, reset, phase_ff != PH_HUNT, count_ff <= CountMax)
   `NSF_ASSERT_SAME(a_ovf_saturated, clock, reset, ovf_ff && phase_ff != PH_HUNT, count_ff == CountMax)
   `NSF_ASSERT_SAME(a_no_overwrite, clock, reset, rsp_valid_ff && rsp_stall, !emit)

endmodule

// ----- hw/rtl/nmea_sentence_framer_unit.sv -----
`timescale 1ns / 1ps
// NMEA 0183 sentence framer: takes one received character per transaction, finds '$', gathers
// the payload up to '*' with a running XOR and a length, reads two hex checksum digits and then
// gives one result with checksum match, sentence type (GSA, GGA, RMC, ZDA or none), talker
// character, payload length saturated at MAX_PAYLOAD, and an overflow flag. It takes one
// character per cycle while req_stall is low: a classifying front register feeds a two-entry
// queue, and the back state machine consumes one queued character per cycle unless it holds
// back a closing digit, which sets the rate. The result is loaded into an output register when
// the back accepts the second checksum digit and waits there while later characters flow; only
// a closing digit that finds it still full is held back. A bad frame still gives checksum_ok low.

module nmea_sentence_framer_unit import nsf_pkg::*; #(
   parameter int MAX_PAYLOAD = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_checksum_ok,
   output logic [2:0] rsp_sentence_type,
   output logic [7:0] rsp_talker_char,
   output logic [7:0] rsp_payload_length,
   output logic       rsp_length_overflow
);

   logic         front_valid;
   logic         front_stall;
   nsf_item_type front_item;
   logic         back_valid;
   logic         back_stall;
   nsf_item_type back_item;

   // Character classification.
   nsf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .out_valid   (front_valid),
      .out_stall   (front_stall),
      .out_item    (front_item)
   );

   // Decoupling queue.
   nsf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_stall  (front_stall),
      .in_item   (front_item),
      .out_valid (back_valid),
      .out_stall (back_stall),
      .out_item  (back_item)
   );

   // Framing state machine and result register.
   nsf_back #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .in_valid            (back_valid),
      .in_stall            (back_stall),
      .in_item             (back_item),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_checksum_ok     (rsp_checksum_ok),
      .rsp_sentence_type   (rsp_sentence_type),
      .rsp_talker_char     (rsp_talker_char),
      .rsp_payload_length  (rsp_payload_length),
      .rsp_length_overflow (rsp_length_overflow)
   );

endmodule
